/* src/tfm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_pkg
// Shared types, codes and sizes of the tiled fp32 matrix multiply core.
// ----------------------------------------------------------------------------
package tfm_pkg;

    // Store sizes
    localparam int MAX_IN_BLOCKS  = 64;
    localparam int MAX_OUT_BLOCKS = 64;
    localparam int TILE_PIX       = 8;
    localparam int LANES          = 4;
    localparam int W_ROWS         = MAX_OUT_BLOCKS * MAX_IN_BLOCKS * 4;
    localparam int S_DEPTH        = MAX_IN_BLOCKS * 32;

    // Input action codes
    localparam logic [1:0] ACT_WGT  = 2'd0;
    localparam logic [1:0] ACT_SRC  = 2'd1;
    localparam logic [1:0] ACT_CMP  = 2'd2;
    localparam logic [1:0] ACT_RSVD = 2'd3;

    // Command kinds passed from front to back
    localparam logic [1:0] KIND_WGT = 2'd0;
    localparam logic [1:0] KIND_SRC = 2'd1;
    localparam logic [1:0] KIND_CMP = 2'd2;
    localparam logic [1:0] KIND_ERR = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_INPUT_BLOCKS = 2'd0;
    localparam logic [1:0] REG_OUT_BLOCKS   = 2'd1;
    localparam logic [1:0] REG_BLOCK_STRIDE = 2'd2;

    // Special fp32 patterns
    localparam logic [31:0] FP_QNAN     = 32'hFFC0_0000;
    localparam logic [31:0] FP_NEG_ZERO = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [5:0]  block;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  pixel;
        logic [21:0] out_address;
        logic [31:0] sum0;
        logic [31:0] sum1;
        logic [31:0] sum2;
        logic [31:0] sum3;
        logic        error;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  input_blocks;
        logic [6:0]  out_blocks;
        logic [15:0] block_stride;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [31:0] value;
        logic [5:0]  ib_m1;
        logic [13:0] wrow;
        logic [21:0] obase;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic [2:0] pixel;
    } sb_t;

endpackage

/* src/tfm_fmul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_fmul
// Three-stage IEEE single multiplier, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module tfm_fmul
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                n     = 6'(47 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Stage 1: unpack, specials, mantissa product
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    logic [23:0] ma, mb;
    logic [7:0]  ea, eb;
    logic        spec;
    logic [31:0] sval;

    logic        s1_spec_reg, s1_sign_reg;
    logic [31:0] s1_sval_reg;
    logic [47:0] s1_p_reg;
    logic signed [9:0] s1_e_reg;

    always_comb
    begin
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        sgn    = a[31] ^ b[31];
        ma     = {(a[30:23] != 8'd0), a[22:0]};
        mb     = {(b[30:23] != 8'd0), b[22:0]};
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        spec   = 1'b1;
        if (a_nan)
            sval = {a[31:23], 1'b1, a[21:0]};
        else if (b_nan)
            sval = {b[31:23], 1'b1, b[21:0]};
        else if ((a_inf && b_zero) || (b_inf && a_zero))
            sval = tfm_pkg::FP_QNAN;
        else if (a_inf || b_inf)
            sval = {sgn, 8'hFF, 23'd0};
        else if (a_zero || b_zero)
            sval = {sgn, 31'd0};
        else
        begin
            spec = 1'b0;
            sval = 32'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_spec_reg <= spec;
        s1_sval_reg <= sval;
        s1_sign_reg <= sgn;
        s1_p_reg    <= ma * mb;
        s1_e_reg    <= $signed({2'b00, ea}) + $signed({2'b00, eb}) - 10'sd126;
    end

    // Stage 2: normalize the product so its leading one sits at the top
    logic [5:0]  lz;
    logic        s2_spec_reg, s2_sign_reg;
    logic [31:0] s2_sval_reg;
    logic [47:0] s2_p_reg;
    logic signed [9:0] s2_e_reg;

    assign lz = lzc48(s1_p_reg);

    always_ff @(posedge clk)
    begin
        s2_spec_reg <= s1_spec_reg;
        s2_sval_reg <= s1_sval_reg;
        s2_sign_reg <= s1_sign_reg;
        s2_p_reg    <= s1_p_reg << lz;
        s2_e_reg    <= s1_e_reg - $signed({4'b0000, lz});
    end

    // Stage 3: denormalize if needed, then round
    logic [9:0]  sh;
    logic [47:0] q;
    logic        lost, g, st, rnd;
    logic [7:0]  ef;
    logic [22:0] mant;
    logic [31:0] res;

    always_comb
    begin
        sh   = 10'($signed(10'sd1) - s2_e_reg);
        q    = s2_p_reg;
        lost = 1'b0;
        ef   = 8'd0;
        if (s2_e_reg < 10'sd1)
        begin
            if (sh >= 10'd48)
            begin
                q    = 48'd0;
                lost = |s2_p_reg;
            end
            else
            begin
                q    = s2_p_reg >> sh[5:0];
                lost = |(s2_p_reg & ((48'd1 << sh[5:0]) - 48'd1));
            end
        end
        else
            ef = s2_e_reg[7:0];
        mant = q[46:24];
        g    = q[23];
        st   = (|q[22:0]) | lost;
        rnd  = g & (st | mant[0]);
        if (s2_spec_reg)
            res = s2_sval_reg;
        else if (s2_e_reg >= 10'sd255)
            res = {s2_sign_reg, 8'hFF, 23'd0};
        else
            res = {s2_sign_reg, {ef, mant} + {30'd0, rnd}};
    end

    always_ff @(posedge clk)
    begin
        y <= res;
    end

endmodule

/* src/tfm_fadd.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_fadd
// Three-stage IEEE single adder, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module tfm_fadd
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                n     = 5'(26 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Stage 1: specials, order by magnitude, align the smaller operand
    logic        a_nan, b_nan, a_inf, b_inf, spec, swap;
    logic [31:0] sval, big, sml;
    logic [7:0]  ebig, esml, d;
    logic [26:0] xs, qs;
    logic        lost;

    logic        s1_spec_reg, s1_sign_reg, s1_sub_reg, s1_zsign_reg;
    logic [31:0] s1_sval_reg;
    logic [7:0]  s1_e_reg;
    logic [26:0] s1_mb_reg, s1_ms_reg;

    always_comb
    begin
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        spec  = 1'b1;
        if (a_nan)
            sval = {a[31:23], 1'b1, a[21:0]};
        else if (b_nan)
            sval = {b[31:23], 1'b1, b[21:0]};
        else if (a_inf && b_inf && (a[31] != b[31]))
            sval = tfm_pkg::FP_QNAN;
        else if (a_inf)
            sval = a;
        else if (b_inf)
            sval = b;
        else
        begin
            spec = 1'b0;
            sval = 32'd0;
        end
        swap = b[30:0] > a[30:0];
        big  = swap ? b : a;
        sml  = swap ? a : b;
        ebig = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        esml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d    = ebig - esml;
        xs   = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
        if (d >= 8'd27)
        begin
            qs   = 27'd0;
            lost = |xs;
        end
        else
        begin
            qs   = xs >> d[4:0];
            lost = |(xs & ((27'd1 << d[4:0]) - 27'd1));
        end
    end

    always_ff @(posedge clk)
    begin
        s1_spec_reg  <= spec;
        s1_sval_reg  <= sval;
        s1_sign_reg  <= big[31];
        s1_sub_reg   <= a[31] ^ b[31];
        s1_zsign_reg <= a[31] & b[31];
        s1_e_reg     <= ebig;
        s1_mb_reg    <= {(big[30:23] != 8'd0), big[22:0], 3'b000};
        s1_ms_reg    <= {qs[26:1], qs[0] | lost};
    end

    // Stage 2: add or subtract, then normalize
    logic [27:0] s;
    logic [4:0]  lz, nsh;
    logic [8:0]  em1;
    logic [26:0] n;
    logic [8:0]  en;

    logic        s2_spec_reg, s2_sign_reg, s2_zero_reg, s2_zsign_reg;
    logic [31:0] s2_sval_reg;
    logic [26:0] s2_n_reg;
    logic [8:0]  s2_e_reg;

    always_comb
    begin
        s   = s1_sub_reg ? ({1'b0, s1_mb_reg} - {1'b0, s1_ms_reg})
                         : ({1'b0, s1_mb_reg} + {1'b0, s1_ms_reg});
        lz  = lzc27(s[26:0]);
        em1 = {1'b0, s1_e_reg} - 9'd1;
        nsh = ({4'd0, lz} < em1) ? lz : em1[4:0];
        if (s[27])
        begin
            n  = {s[27:2], s[1] | s[0]};
            en = {1'b0, s1_e_reg} + 9'd1;
        end
        else
        begin
            n  = s[26:0] << nsh;
            en = {1'b0, s1_e_reg} - {4'd0, nsh};
        end
    end

    always_ff @(posedge clk)
    begin
        s2_spec_reg  <= s1_spec_reg;
        s2_sval_reg  <= s1_sval_reg;
        s2_sign_reg  <= s1_sign_reg;
        s2_zsign_reg <= s1_zsign_reg;
        s2_zero_reg  <= (s == 28'd0);
        s2_n_reg     <= n;
        s2_e_reg     <= en;
    end

    // Stage 3: round and pack
    logic [7:0]  ef;
    logic        rnd;
    logic [31:0] res;

    always_comb
    begin
        ef  = s2_n_reg[26] ? s2_e_reg[7:0] : 8'd0;
        rnd = s2_n_reg[2] & (s2_n_reg[1] | s2_n_reg[0] | s2_n_reg[3]);
        if (s2_spec_reg)
            res = s2_sval_reg;
        else if (s2_zero_reg)
            res = {s2_zsign_reg, 31'd0};
        else if (s2_e_reg >= 9'd255)
            res = {s2_sign_reg, 8'hFF, 23'd0};
        else
            res = {s2_sign_reg, {ef, s2_n_reg[25:3]} + {30'd0, rnd}};
    end

    always_ff @(posedge clk)
    begin
        y <= res;
    end

endmodule

/* src/tfm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_front
// Accepts input items, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module tfm_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tfm_pkg::in_item_t  in_data,
    input  tfm_pkg::cfg_t      cfg,
    output logic               cmd_valid,
    input  logic               cmd_pop,
    output tfm_pkg::cmd_t      cmd
);

    logic [6:0]     ib_eff, ob_eff;
    logic [12:0]    wprod;
    logic           keep, push;
    tfm_pkg::cmd_t  new_cmd;

    // Classify the incoming item
    always_comb
    begin
        if (cfg.input_blocks == 7'd0)
            ib_eff = 7'd1;
        else if (cfg.input_blocks > 7'(tfm_pkg::MAX_IN_BLOCKS))
            ib_eff = 7'(tfm_pkg::MAX_IN_BLOCKS);
        else
            ib_eff = cfg.input_blocks;
        if (cfg.out_blocks > 7'(tfm_pkg::MAX_OUT_BLOCKS))
            ob_eff = 7'(tfm_pkg::MAX_OUT_BLOCKS);
        else
            ob_eff = cfg.out_blocks;
        wprod           = 13'(in_data.block) * 13'(ib_eff);
        new_cmd.address = in_data.address;
        new_cmd.value   = in_data.value;
        new_cmd.ib_m1   = 6'(ib_eff - 7'd1);
        new_cmd.wrow    = {wprod[11:0], 2'b00};
        new_cmd.obase   = 22'(in_data.block) * 22'(cfg.block_stride);
        unique case (in_data.action)
            tfm_pkg::ACT_WGT:
            begin
                new_cmd.kind = tfm_pkg::KIND_WGT;
                keep         = 1'b1;
            end
            tfm_pkg::ACT_SRC:
            begin
                new_cmd.kind = tfm_pkg::KIND_SRC;
                keep         = {1'b0, in_data.address} < 17'(tfm_pkg::S_DEPTH);
            end
            tfm_pkg::ACT_CMP:
            begin
                new_cmd.kind = ({1'b0, in_data.block} >= ob_eff) ? tfm_pkg::KIND_ERR
                                                                 : tfm_pkg::KIND_CMP;
                keep         = 1'b1;
            end
            default:
            begin
                new_cmd.kind = tfm_pkg::KIND_WGT;
                keep         = 1'b0;
            end
        endcase
    end

    // Two-entry command queue
    logic [1:0]    cnt_reg, cnt_next;
    tfm_pkg::cmd_t q_reg [2];
    logic          wr_low;

    assign in_stall  = (cnt_reg == 2'd2);
    assign push      = in_valid & ~in_stall & keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[0];
    assign wr_low    = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && cmd_pop);
    assign cnt_next  = cnt_reg - {1'b0, cmd_pop} + {1'b0, push};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    // Advance and fill queue entries
    always_ff @(posedge clk)
    begin
        if (push && wr_low)
            q_reg[0] <= new_cmd;
        else if (cmd_pop)
            q_reg[0] <= q_reg[1];
        if (push && !wr_low)
            q_reg[1] <= new_cmd;
    end

endmodule

/* src/tfm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_back
// Executes store writes and block computes; holds the stores, the
// multiply-accumulate pipeline and the result queue.
// ----------------------------------------------------------------------------
module tfm_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  tfm_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output tfm_pkg::out_item_t out_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]  state_reg;
    logic [7:0]  step_reg, last_step_reg;
    logic [2:0]  pix_reg;
    logic [13:0] wrow_reg;
    logic [21:0] obase_reg;
    logic [3:0]  fcnt_reg;

    logic take_wr, take_cmp, wgt_we, src_we, issue, pipe_push, err_push, drain_done;
    logic is_wr;

    // Take commands while idle
    always_comb
    begin
        is_wr    = (cmd.kind == tfm_pkg::KIND_WGT) || (cmd.kind == tfm_pkg::KIND_SRC);
        take_wr  = (state_reg == ST_IDLE) && cmd_valid && is_wr;
        take_cmp = (state_reg == ST_IDLE) && cmd_valid && !is_wr && (fcnt_reg == 4'd0);
        cmd_pop  = take_wr | take_cmp;
        wgt_we   = take_wr && (cmd.kind == tfm_pkg::KIND_WGT);
        src_we   = take_wr && (cmd.kind == tfm_pkg::KIND_SRC);
        err_push = take_cmp && (cmd.kind == tfm_pkg::KIND_ERR);
        issue    = (state_reg == ST_RUN);
    end

    // Sequencer over steps (k, c) and interleaved pixels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 8'd0;
            pix_reg       <= 3'd0;
            last_step_reg <= 8'd0;
            wrow_reg      <= 14'd0;
            obase_reg     <= 22'd0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take_cmp && (cmd.kind == tfm_pkg::KIND_CMP))
                    begin
                        step_reg      <= 8'd0;
                        pix_reg       <= 3'd0;
                        last_step_reg <= {cmd.ib_m1, 2'b11};
                        wrow_reg      <= cmd.wrow;
                        obase_reg     <= cmd.obase;
                        state_reg     <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    pix_reg <= pix_reg + 3'd1;
                    if (pix_reg == 3'(tfm_pkg::TILE_PIX - 1))
                    begin
                        step_reg <= step_reg + 8'd1;
                        if (step_reg == last_step_reg)
                            state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (drain_done)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Stores: weights split into one memory per output lane
    logic [13:0] rrow;
    logic [10:0] saddr;
    logic [31:0] wq_reg [tfm_pkg::LANES];
    logic [31:0] sq_reg;
    logic [31:0] smem [tfm_pkg::S_DEPTH];

    assign rrow  = wrow_reg + {6'd0, step_reg};
    assign saddr = {step_reg[7:2], pix_reg, step_reg[1:0]};

    for (genvar gl = 0; gl < tfm_pkg::LANES; gl++)
    begin : g_wlane
        logic [31:0] wmem [tfm_pkg::W_ROWS];
        always_ff @(posedge clk)
        begin
            if (wgt_we && (cmd.address[1:0] == 2'(gl)))
                wmem[cmd.address[15:2]] <= cmd.value;
            wq_reg[gl] <= wmem[rrow];
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_we)
            smem[cmd.address[10:0]] <= cmd.value;
        sq_reg <= smem[saddr];
    end

    // Sideband travelling alongside the datapath
    tfm_pkg::sb_t sb_issue;
    tfm_pkg::sb_t sb_reg [1:7];

    always_comb
    begin
        sb_issue.valid = issue;
        sb_issue.first = (step_reg == 8'd0);
        sb_issue.last  = (step_reg == last_step_reg);
        sb_issue.pixel = pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 7; i++)
                sb_reg[i] <= '0;
        end
        else
        begin
            sb_reg[1] <= sb_issue;
            for (int i = 2; i <= 7; i++)
                sb_reg[i] <= sb_reg[i-1];
        end
    end

    // Multiply and accumulate lanes; the feedback line closes the
    // loop through the adder so each pixel meets its own partial sum
    logic [31:0] prod [tfm_pkg::LANES];
    logic [31:0] acc_in [tfm_pkg::LANES];
    logic [31:0] sum [tfm_pkg::LANES];
    logic [31:0] fb_reg [5][tfm_pkg::LANES];

    for (genvar gl = 0; gl < tfm_pkg::LANES; gl++)
    begin : g_mac
        tfm_fmul u_fmul
        (
            .clk (clk),
            .a   (wq_reg[gl]),
            .b   (sq_reg),
            .y   (prod[gl])
        );

        assign acc_in[gl] = sb_reg[4].first ? tfm_pkg::FP_NEG_ZERO : fb_reg[4][gl];

        tfm_fadd u_fadd
        (
            .clk (clk),
            .a   (acc_in[gl]),
            .b   (prod[gl]),
            .y   (sum[gl])
        );
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < tfm_pkg::LANES; l++)
        begin
            fb_reg[0][l] <= sum[l];
            for (int i = 1; i < 5; i++)
                fb_reg[i][l] <= fb_reg[i-1][l];
        end
    end

    // Result assembly
    tfm_pkg::out_item_t push_item;

    always_comb
    begin
        pipe_push  = sb_reg[7].valid && sb_reg[7].last;
        drain_done = pipe_push && (sb_reg[7].pixel == 3'(tfm_pkg::TILE_PIX - 1));
        if (err_push)
        begin
            push_item       = '0;
            push_item.error = 1'b1;
            push_item.last  = 1'b1;
        end
        else
        begin
            push_item.pixel       = sb_reg[7].pixel;
            push_item.out_address = obase_reg + {17'd0, sb_reg[7].pixel, 2'b00};
            push_item.sum0        = sum[0];
            push_item.sum1        = sum[1];
            push_item.sum2        = sum[2];
            push_item.sum3        = sum[3];
            push_item.error       = 1'b0;
            push_item.last        = (sb_reg[7].pixel == 3'(tfm_pkg::TILE_PIX - 1));
        end
    end

    // Result queue, one entry per pixel of a tile
    tfm_pkg::out_item_t fifo_reg [tfm_pkg::TILE_PIX];
    logic [2:0] wr_ptr_reg, rd_ptr_reg;
    logic       fpush, fpop;

    assign fpush     = pipe_push | err_push;
    assign out_valid = (fcnt_reg != 4'd0);
    assign out_data  = fifo_reg[rd_ptr_reg];
    assign fpop      = out_valid & ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 3'd0;
            rd_ptr_reg <= 3'd0;
            fcnt_reg   <= 4'd0;
        end
        else
        begin
            if (fpush)
                wr_ptr_reg <= wr_ptr_reg + 3'd1;
            if (fpop)
                rd_ptr_reg <= rd_ptr_reg + 3'd1;
            fcnt_reg <= fcnt_reg + {3'd0, fpush} - {3'd0, fpop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (fpush)
            fifo_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* src/tiled_fp32_matmul_8x4_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_fp32_matmul_8x4_core
// Tiled fp32 matrix multiply: 8 pixels by 4 output channels per block.
// ----------------------------------------------------------------------------
// Store writes (weight or source words) are taken one per cycle while the
// back end is idle. A compute request walks input_blocks*4 weight rows,
// reading one row of four weights and one source word per cycle and
// interleaving the eight pixels; its eight results leave the multiply and
// add pipelines into the result queue. A compute starts only once the
// result queue is empty. An out-of-range block gives one error result and
// no compute. Sums follow IEEE single rounding to nearest even, a separate
// multiply and add per term, in ascending input channel order.
module tiled_fp32_matmul_8x4_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tfm_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output tfm_pkg::out_item_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration registers
    tfm_pkg::cfg_t cfg_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_blocks <= 7'd1;
            cfg_reg.out_blocks   <= 7'd1;
            cfg_reg.block_stride <= 16'd32;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                tfm_pkg::REG_INPUT_BLOCKS: cfg_reg.input_blocks <= pwdata[6:0];
                tfm_pkg::REG_OUT_BLOCKS:   cfg_reg.out_blocks   <= pwdata[6:0];
                tfm_pkg::REG_BLOCK_STRIDE: cfg_reg.block_stride <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            tfm_pkg::REG_INPUT_BLOCKS: prdata = {25'd0, cfg_reg.input_blocks};
            tfm_pkg::REG_OUT_BLOCKS:   prdata = {25'd0, cfg_reg.out_blocks};
            tfm_pkg::REG_BLOCK_STRIDE: prdata = {16'd0, cfg_reg.block_stride};
            default:                   prdata = 32'd0;
        endcase
    end

    // Front end and command queue
    logic          cmd_valid, cmd_pop;
    tfm_pkg::cmd_t cmd;

    tfm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // Back end
    tfm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Checks
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error |-> out_data.last)
        else $error("error result without last");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error |-> out_data.pixel == 3'd0 && out_data.sum0 == 32'd0)
        else $error("error result carries data");

    a_last_pix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.error |-> out_data.last == (out_data.pixel == 3'd7))
        else $error("last flag not on final pixel");

endmodule
